// ===== rtl/conservative_to_primitive_assert.svh =====
// ----------------------------------------------------------------------------
// conservative_to_primitive_assert.svh
// Assertion macros shared by the conversion block.
// ----------------------------------------------------------------------------
`ifndef CONSERVATIVE_TO_PRIMITIVE_ASSERT_SVH
`define CONSERVATIVE_TO_PRIMITIVE_ASSERT_SVH

// same-cycle implication
`define CTP_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ctp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctp_pkg
// Widths, register codes, pipeline types and divider step functions.
// ----------------------------------------------------------------------------
package ctp_pkg;

	localparam int CTP_W       = 32;
	localparam int CTP_U31_W   = 31;
	localparam int CTP_GAMMA_W = 18;
	localparam int CTP_IDX_W   = 2;
	localparam int CTP_CFG_W   = 32;
	localparam int CTP_DEN_W   = 62;

	localparam logic [CTP_GAMMA_W-1:0] CTP_GAMMA_RST = 18'd91750;
	localparam logic [CTP_U31_W-1:0]   CTP_COEFF_RST = 31'd65536;
	localparam logic [CTP_GAMMA_W-1:0] CTP_ONE_G     = 18'd65536;
	localparam logic [CTP_U31_W-1:0]   CTP_MAX_U31   = 31'h7FFF_FFFF;
	localparam logic [CTP_W-1:0]       CTP_MAX_S32   = 32'h7FFF_FFFF;
	localparam logic [CTP_W-1:0]       CTP_MIN_S32   = 32'h8000_0000;
	localparam logic [40:0]            CTP_KE_CAP    = 41'h100_0000_0000;

	typedef enum logic [CTP_IDX_W-1:0] {
		CTP_REG_GAMMA   = 2'd0,
		CTP_REG_COEFF_A = 2'd1,
		CTP_REG_COEFF_B = 2'd2
	} ctp_reg_t;

	typedef struct packed {
		logic        ovf;
		logic        neg;
		logic [30:0] rem;
		logic [31:0] low;
		logic [31:0] quot;
	} ctp_vdiv_t;

	typedef struct packed {
		logic [30:0]        rho;
		logic [30:0]        coeff;
		logic signed [31:0] energy;
	} ctp_side_t;

	typedef struct packed {
		logic        ovf;
		logic [61:0] rem;
		logic [61:0] den;
		logic [30:0] quot;
	} ctp_tdiv_t;

	function automatic ctp_vdiv_t ctp_vstep(ctp_vdiv_t d, logic [30:0] rho);
		logic [31:0] r2;
		ctp_vdiv_t   o;
		o = d;
		r2 = {d.rem, d.low[31]};
		o.low = {d.low[30:0], 1'b0};
		if (r2 >= {1'b0, rho}) begin
			o.rem  = 31'(r2 - {1'b0, rho});
			o.quot = {d.quot[30:0], 1'b1};
		end else begin
			o.rem  = r2[30:0];
			o.quot = {d.quot[30:0], 1'b0};
		end
		return o;
	endfunction

	function automatic ctp_tdiv_t ctp_tstep(ctp_tdiv_t d);
		logic [62:0] r2;
		ctp_tdiv_t   o;
		o = d;
		r2 = {d.rem, 1'b0};
		if (r2 >= {1'b0, d.den}) begin
			o.rem  = 62'(r2 - {1'b0, d.den});
			o.quot = {d.quot[29:0], 1'b1};
		end else begin
			o.rem  = r2[61:0];
			o.quot = {d.quot[29:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ===== rtl/ctp_cell_if.sv =====
// ----------------------------------------------------------------------------
// ctp_cell_if
// Input channel: one cell of conserved state per transaction.
// ----------------------------------------------------------------------------
interface ctp_cell_if import ctp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    species;
	logic signed [CTP_W-1:0] density;
	logic signed [CTP_W-1:0] momentum_x;
	logic signed [CTP_W-1:0] momentum_y;
	logic signed [CTP_W-1:0] momentum_z;
	logic signed [CTP_W-1:0] total_energy;

	modport source (output valid, species, density, momentum_x, momentum_y,
		momentum_z, total_energy, input ready);
	modport sink (input valid, species, density, momentum_x, momentum_y,
		momentum_z, total_energy, output ready);
endinterface

// ===== rtl/ctp_prim_if.sv =====
// ----------------------------------------------------------------------------
// ctp_prim_if
// Output channel: one cell of primitive state per transaction.
// ----------------------------------------------------------------------------
interface ctp_prim_if import ctp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CTP_W-1:0] velocity_x;
	logic signed [CTP_W-1:0] velocity_y;
	logic signed [CTP_W-1:0] velocity_z;
	logic [CTP_U31_W-1:0]    pressure;
	logic [CTP_U31_W-1:0]    temperature;

	modport source (output valid, velocity_x, velocity_y, velocity_z, pressure,
		temperature, input ready);
	modport sink (input valid, velocity_x, velocity_y, velocity_z, pressure,
		temperature, output ready);
endinterface

// ===== rtl/ctp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ctp_cfg_if
// Configuration write channel: register index and data per transaction.
// ----------------------------------------------------------------------------
interface ctp_cfg_if import ctp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CTP_IDX_W-1:0] index;
	logic [CTP_CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/conservative_to_primitive.sv =====
// ----------------------------------------------------------------------------
// conservative_to_primitive
// Euler conserved-to-primitive conversion, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one cell per clock unless the output stalls, and returns its
// velocities, pressure and temperature. It uses two restoring dividers
// laid out one quotient bit per stage: 32 stages for the three velocity
// quotients (run side by side) and 31 stages for temperature, plus ten
// stages of clamping, multiplies and the kinetic energy sum. A stall at the
// output holds the whole pipeline. Configuration writes are always ready and
// take effect at once; write them only while the pipeline is empty.
`include "conservative_to_primitive_assert.svh"

module conservative_to_primitive import ctp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ctp_cell_if.sink  cells,
	ctp_prim_if.source prims,
	ctp_cfg_if.sink   cfg
);

	localparam int VDIV_N = 32;
	localparam int TDIV_N = 31;

	logic adv;

	logic [CTP_GAMMA_W-1:0] gamma_q;
	logic [CTP_U31_W-1:0]   coeff_a_q;
	logic [CTP_U31_W-1:0]   coeff_b_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q   <= CTP_GAMMA_RST;
			coeff_a_q <= CTP_COEFF_RST;
			coeff_b_q <= CTP_COEFF_RST;
		end else if (cfg.valid) begin
			case (ctp_reg_t'(cfg.index))
				CTP_REG_GAMMA:   gamma_q   <= cfg.data[CTP_GAMMA_W-1:0];
				CTP_REG_COEFF_A: coeff_a_q <= cfg.data[CTP_U31_W-1:0];
				CTP_REG_COEFF_B: coeff_b_q <= cfg.data[CTP_U31_W-1:0];
				default: ;
			endcase
		end
	end

	// valid chain
	logic                v_s1;
	logic [VDIV_N-1:0]   v_s2;
	logic                v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [TDIV_N-1:0]   v_s11;
	logic                v_s12;

	assign adv         = !v_s12 || prims.ready;
	assign cells.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= '0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= '0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s1  <= cells.valid;
			v_s2  <= {v_s2[VDIV_N-2:0], v_s1};
			v_s3  <= v_s2[VDIV_N-1];
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= {v_s11[TDIV_N-2:0], v_s10};
			v_s12 <= v_s11[TDIV_N-1];
		end
	end

	// stage 1: density floor, magnitudes, divider setup
	logic signed [CTP_W-1:0] mom_c [3];
	logic [30:0]             rho_c;
	logic [CTP_W-1:0]        mag_c [3];
	ctp_vdiv_t               init_c [3];

	always_comb begin
		mom_c[0] = cells.momentum_x;
		mom_c[1] = cells.momentum_y;
		mom_c[2] = cells.momentum_z;
		rho_c = (cells.density < 32'sd1) ? 31'd1 : cells.density[30:0];
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = mom_c[i][31] ? 32'(-mom_c[i]) : 32'(mom_c[i]);
			init_c[i].ovf  = {16'h0, mag_c[i][31:16]} >= {1'b0, rho_c};
			init_c[i].neg  = mom_c[i][31];
			init_c[i].rem  = {15'h0, mag_c[i][31:16]};
			init_c[i].low  = {mag_c[i][15:0], 16'h0};
			init_c[i].quot = '0;
		end
	end

	ctp_vdiv_t dv_s1 [3];
	ctp_side_t side_s1;
	ctp_vdiv_t dv_s2 [VDIV_N][3];
	ctp_side_t side_s2 [VDIV_N];

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s1          <= init_c;
			side_s1.rho    <= rho_c;
			side_s1.coeff  <= cells.species ? coeff_b_q : coeff_a_q;
			side_s1.energy <= cells.total_energy;
			for (int i = 0; i < 3; i++) begin
				dv_s2[0][i] <= ctp_vstep(dv_s1[i], side_s1.rho);
			end
			side_s2[0] <= side_s1;
			for (int k = 1; k < VDIV_N; k++) begin
				for (int i = 0; i < 3; i++) begin
					dv_s2[k][i] <= ctp_vstep(dv_s2[k-1][i], side_s2[k-1].rho);
				end
				side_s2[k] <= side_s2[k-1];
			end
		end
	end

	// stage 3: velocity saturation
	logic signed [CTP_W-1:0] vel_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_s2[VDIV_N-1][i].ovf) begin
				vel_c[i] = dv_s2[VDIV_N-1][i].neg ? CTP_MIN_S32 : CTP_MAX_S32;
			end else if (!dv_s2[VDIV_N-1][i].neg) begin
				vel_c[i] = dv_s2[VDIV_N-1][i].quot[31] ? CTP_MAX_S32
					: dv_s2[VDIV_N-1][i].quot;
			end else if (dv_s2[VDIV_N-1][i].quot[31]
				&& (dv_s2[VDIV_N-1][i].quot[30:0] != '0)) begin
				vel_c[i] = CTP_MIN_S32;
			end else begin
				vel_c[i] = -dv_s2[VDIV_N-1][i].quot;
			end
		end
	end

	logic signed [CTP_W-1:0] vel_s3 [3];
	logic [30:0]             rho_s3, coeff_s3;
	logic signed [CTP_W-1:0] energy_s3;

	logic signed [CTP_W-1:0] vel_s4 [3];
	logic [62:0]             sq_s4 [3];
	logic [CTP_DEN_W-1:0]    den_s4;
	logic [30:0]             rho_s4;
	logic signed [CTP_W-1:0] energy_s4;

	logic signed [CTP_W-1:0] vel_s5 [3];
	logic [63:0]             sum_s5;
	logic [CTP_DEN_W-1:0]    den_s5;
	logic [30:0]             rho_s5;
	logic signed [CTP_W-1:0] energy_s5;

	logic signed [CTP_W-1:0] vel_s6 [3];
	logic [62:0]             pa_s6, pb_s6;
	logic [CTP_DEN_W-1:0]    den_s6;
	logic signed [CTP_W-1:0] energy_s6;

	logic signed [CTP_W-1:0] vel_s7 [3];
	logic [40:0]             ke_s7;
	logic [CTP_DEN_W-1:0]    den_s7;
	logic signed [CTP_W-1:0] energy_s7;

	logic signed [CTP_W-1:0] vel_s8 [3];
	logic [30:0]             eint_s8;
	logic [CTP_GAMMA_W-1:0]  gm1_s8;
	logic                    gpos_s8;
	logic [CTP_DEN_W-1:0]    den_s8;

	logic signed [CTP_W-1:0] vel_s9 [3];
	logic [48:0]             prod_s9;
	logic                    gpos_s9;
	logic [CTP_DEN_W-1:0]    den_s9;

	logic signed [CTP_W-1:0] vel_s10 [3];
	logic [30:0]             p_s10;
	ctp_tdiv_t               td_s10;

	logic signed [63:0]      sq_c [3];
	logic [63:0]             rest_c;
	logic [62:0]             ke_c;
	logic signed [41:0]      diff_c;
	logic [32:0]             pq_c;
	logic [30:0]             p_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = 64'(vel_s3[i]) * 64'(vel_s3[i]);
		end
		rest_c = {31'h0, pa_s6[0], 32'h0} + {1'b0, pb_s6};
		ke_c   = {1'b0, pa_s6[62:1]} + {32'h0, rest_c[63:33]};
		diff_c = 42'(energy_s7) - $signed({1'b0, ke_s7});
		pq_c   = prod_s9[48:16];
		if (!gpos_s9) begin
			p_c = 31'd1;
		end else if (pq_c > {2'b00, CTP_MAX_U31}) begin
			p_c = CTP_MAX_U31;
		end else if (pq_c == '0) begin
			p_c = 31'd1;
		end else begin
			p_c = pq_c[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_s3    <= vel_c;
			rho_s3    <= side_s2[VDIV_N-1].rho;
			coeff_s3  <= side_s2[VDIV_N-1].coeff;
			energy_s3 <= side_s2[VDIV_N-1].energy;

			vel_s4    <= vel_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= sq_c[i][62:0];
			end
			den_s4    <= 62'(rho_s3) * 62'(coeff_s3);
			rho_s4    <= rho_s3;
			energy_s4 <= energy_s3;

			vel_s5    <= vel_s4;
			sum_s5    <= {1'b0, sq_s4[0]} + {1'b0, sq_s4[1]} + {1'b0, sq_s4[2]};
			den_s5    <= den_s4;
			rho_s5    <= rho_s4;
			energy_s5 <= energy_s4;

			vel_s6    <= vel_s5;
			pa_s6     <= 63'(sum_s5[63:32]) * 63'(rho_s5);
			pb_s6     <= 63'(sum_s5[31:0]) * 63'(rho_s5);
			den_s6    <= den_s5;
			energy_s6 <= energy_s5;

			vel_s7    <= vel_s6;
			ke_s7     <= (ke_c > 63'(CTP_KE_CAP)) ? CTP_KE_CAP : ke_c[40:0];
			den_s7    <= den_s6;
			energy_s7 <= energy_s6;

			vel_s8    <= vel_s7;
			eint_s8   <= diff_c[41] ? 31'd0 : diff_c[30:0];
			gpos_s8   <= gamma_q > CTP_ONE_G;
			gm1_s8    <= gamma_q - CTP_ONE_G;
			den_s8    <= den_s7;

			vel_s9    <= vel_s8;
			prod_s9   <= 49'(gm1_s8) * 49'(eint_s8);
			gpos_s9   <= gpos_s8;
			den_s9    <= den_s8;

			vel_s10     <= vel_s9;
			p_s10       <= p_c;
			td_s10.ovf  <= {30'h0, p_c, 1'b0} >= den_s9;
			td_s10.rem  <= {30'h0, p_c, 1'b0};
			td_s10.den  <= den_s9;
			td_s10.quot <= '0;
		end
	end

	// stage 11: temperature divider
	ctp_tdiv_t               td_s11 [TDIV_N];
	logic signed [CTP_W-1:0] vel_s11 [TDIV_N][3];
	logic [30:0]             p_s11 [TDIV_N];

	always_ff @(posedge clk) begin
		if (adv) begin
			td_s11[0]  <= ctp_tstep(td_s10);
			vel_s11[0] <= vel_s10;
			p_s11[0]   <= p_s10;
			for (int k = 1; k < TDIV_N; k++) begin
				td_s11[k]  <= ctp_tstep(td_s11[k-1]);
				vel_s11[k] <= vel_s11[k-1];
				p_s11[k]   <= p_s11[k-1];
			end
		end
	end

	// stage 12: output register
	logic signed [CTP_W-1:0] vel_s12 [3];
	logic [30:0]             p_s12, t_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_s12 <= vel_s11[TDIV_N-1];
			p_s12   <= p_s11[TDIV_N-1];
			t_s12   <= td_s11[TDIV_N-1].ovf ? CTP_MAX_U31 : td_s11[TDIV_N-1].quot;
		end
	end

	assign prims.valid       = v_s12;
	assign prims.velocity_x  = vel_s12[0];
	assign prims.velocity_y  = vel_s12[1];
	assign prims.velocity_z  = vel_s12[2];
	assign prims.pressure    = p_s12;
	assign prims.temperature = t_s12;

	`CTP_ASSERT_IMP(a_pressure_floor, clk, arst_n, prims.valid, prims.pressure != '0, "pressure below one LSB")
	`CTP_ASSERT_IMP(a_stall_blocks_in, clk, arst_n, prims.valid && !prims.ready, !cells.ready, "input taken during output stall")
	`CTP_ASSERT_NEXT(a_enter_s1, clk, arst_n, cells.valid && cells.ready, v_s1, "accepted transaction missing in stage 1")

endmodule

// ===== dv/ctp_checker.sv =====
// ----------------------------------------------------------------------------
// ctp_checker
// Watches the cell, primitive and configuration channels of the conversion
// block. It predicts velocities, pressure and temperature for every accepted
// cell and compares each returned transaction, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_checker import ctp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ctp_cell_if  cells,
	ctp_prim_if  prims,
	ctp_cfg_if   cfg,
	output int   fails,
	output int   pending
);

	typedef struct {
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [30:0] p;
		logic [30:0] t;
	} prim_t;

	prim_t             prim_q[$];
	logic [17:0]       gamma_q;
	logic [30:0]       coeff_a;
	logic [30:0]       coeff_b;

	function automatic longint velocity_sat(longint mom, longint rho);
		longint q;
		q = (mom * 65536) / rho;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q;
	endfunction

	function automatic prim_t convert_cell(logic sp, logic [31:0] d, logic [31:0] mx,
		logic [31:0] my, logic [31:0] mz, logic [31:0] e);
		longint      rho, vx, vy, vz, eint, gm1;
		logic [63:0] s, ke, p, t, den;
		logic [95:0] prod;
		logic [30:0] coeff;
		prim_t       r;
		coeff = sp ? coeff_b : coeff_a;
		rho = longint'(signed'(d));
		if (rho < 1)
			rho = 1;
		vx = velocity_sat(longint'(signed'(mx)), rho);
		vy = velocity_sat(longint'(signed'(my)), rho);
		vz = velocity_sat(longint'(signed'(mz)), rho);
		s = 64'(vx * vx) + 64'(vy * vy) + 64'(vz * vz);
		prod = {32'b0, s} * {32'b0, 64'(rho)};
		ke = 64'(prod >> 33);
		if (ke > 64'h100_0000_0000)
			ke = 64'h100_0000_0000;
		eint = longint'(signed'(e)) - longint'(ke);
		if (eint < 0)
			eint = 0;
		gm1 = longint'({46'b0, gamma_q}) - 65536;
		if (gm1 <= 0) begin
			p = 1;
		end else begin
			p = (64'(gm1) * 64'(eint)) >> 16;
			if (p > 64'h7FFF_FFFF)
				p = 64'h7FFF_FFFF;
			if (p < 1)
				p = 1;
		end
		den = 64'(rho) * {33'b0, coeff};
		if (den == 0) begin
			t = 64'h7FFF_FFFF;
		end else begin
			t = (p << 32) / den;
			if (t > 64'h7FFF_FFFF)
				t = 64'h7FFF_FFFF;
		end
		r.vx = 32'(vx);
		r.vy = 32'(vy);
		r.vz = 32'(vz);
		r.p = 31'(p);
		r.t = 31'(t);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		prim_t x;
		if (!arst_n) begin
			gamma_q = CTP_GAMMA_RST;
			coeff_a = CTP_COEFF_RST;
			coeff_b = CTP_COEFF_RST;
			prim_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CTP_REG_GAMMA:   gamma_q = cfg.data[17:0];
					CTP_REG_COEFF_A: coeff_a = cfg.data[30:0];
					CTP_REG_COEFF_B: coeff_b = cfg.data[30:0];
					default: ;
				endcase
			end
			if (cells.valid && cells.ready)
				prim_q.push_back(convert_cell(cells.species, cells.density,
					cells.momentum_x, cells.momentum_y, cells.momentum_z,
					cells.total_energy));
			if (prims.valid && prims.ready) begin
				if (prim_q.size() == 0) begin
					$error("unexpected primitive transaction");
					fails++;
				end else begin
					x = prim_q.pop_front();
					if (prims.velocity_x !== x.vx) begin
						$error("velocity_x exp %h got %h", x.vx, prims.velocity_x);
						fails++;
					end
					if (prims.velocity_y !== x.vy) begin
						$error("velocity_y exp %h got %h", x.vy, prims.velocity_y);
						fails++;
					end
					if (prims.velocity_z !== x.vz) begin
						$error("velocity_z exp %h got %h", x.vz, prims.velocity_z);
						fails++;
					end
					if (prims.pressure !== x.p) begin
						$error("pressure exp %h got %h", x.p, prims.pressure);
						fails++;
					end
					if (prims.temperature !== x.t) begin
						$error("temperature exp %h got %h", x.t, prims.temperature);
						fails++;
					end
				end
			end
			pending = prim_q.size();
		end
	end

endmodule

// ===== dv/tb_conservative_to_primitive.sv =====
// ----------------------------------------------------------------------------
// tb_conservative_to_primitive
// Drives conserved cells and register writes into the conversion block
// through several gamma and coefficient settings, extremes included, with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_conservative_to_primitive;
	import ctp_pkg::*;

	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 5000;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   quiet;
	bit   no_gaps;

	ctp_cell_if cells_if();
	ctp_prim_if prims_if();
	ctp_cfg_if  cfg_if();

	conservative_to_primitive dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cells  (cells_if),
		.prims  (prims_if),
		.cfg    (cfg_if)
	);

	ctp_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cells   (cells_if),
		.prims   (prims_if),
		.cfg     (cfg_if),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	function automatic logic [31:0] rand_q16(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(2 * 65536)) - 65536);
			2: return 32'($urandom_range(40 * 65536));
			3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	// output stalls: bursts of random length
	initial begin
		int n;
		prims_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			prims_if.ready = 1'b1;
			n = no_gaps ? 50 : $urandom_range(20, 1);
			repeat (n - 1) @(negedge clk);
			n = gap_len();
			if (n > 0) begin
				@(negedge clk);
				prims_if.ready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((cells_if.valid && cells_if.ready) || (prims_if.valid && prims_if.ready)
			|| (cfg_if.valid && cfg_if.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_cell(logic sp, logic [31:0] d, logic [31:0] mx,
		logic [31:0] my, logic [31:0] mz, logic [31:0] e);
		int n;
		n = gap_len();
		if (n > 0) begin
			cells_if.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		cells_if.valid = 1'b1;
		cells_if.species = sp;
		cells_if.density = d;
		cells_if.momentum_x = mx;
		cells_if.momentum_y = my;
		cells_if.momentum_z = mz;
		cells_if.total_energy = e;
		do @(posedge clk); while (!cells_if.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cells_if.valid = 1'b0;
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = val;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic drain();
		cells_if.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(logic [31:0] g, logic [31:0] a, logic [31:0] b);
		drain();
		write_reg(CTP_REG_GAMMA, g);
		write_reg(CTP_REG_COEFF_A, a);
		write_reg(CTP_REG_COEFF_B, b);
	endtask

	task automatic random_cells(int count);
		logic [31:0] d;
		int          m;
		repeat (count) begin
			m = $urandom_range(99);
			if (m < 70)
				d = 32'($urandom_range(8 * 65536, 1));
			else if (m < 80)
				d = $urandom_range(1) ? 32'(-$signed($urandom_range(65536))) : 32'd0;
			else
				d = rand_q16($urandom_range(3));
			m = $urandom_range(4);
			send_cell(1'($urandom_range(1)), d, rand_q16(m), rand_q16(m), rand_q16(m),
				rand_q16($urandom_range(4)));
		end
	endtask

	initial begin
		logic [31:0] mx;
		logic [31:0] mn;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		arst_n = 1'b0;
		no_gaps = 1'b0;
		cells_if.valid = 1'b0;
		cells_if.species = 1'b0;
		cells_if.density = '0;
		cells_if.momentum_x = '0;
		cells_if.momentum_y = '0;
		cells_if.momentum_z = '0;
		cells_if.total_energy = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CTP_REG_GAMMA;
		cfg_if.data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: floors, saturation, energy clamp, both species
		send_cell(1'b0, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd10 << 16);
		send_cell(1'b1, 32'd0, mx, mn, 32'd1, mx);
		send_cell(1'b0, mn, mn, mx, mn, mn);
		send_cell(1'b1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		send_cell(1'b0, mx, mx, mx, mx, mx);
		send_cell(1'b1, mx, mn, mn, mn, mn);
		send_cell(1'b0, 32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFD, 32'd0, 32'd1);
		send_cell(1'b1, 32'd3 << 16, 32'd1 << 16, 32'd2 << 16, 32'd4 << 16, 32'd1);
		random_cells(190);

		set_config(32'hFFFC_0000 | 32'd196608, 32'h8000_0001, 32'h7FFF_FFFF);
		write_reg(2'd3, 32'hFFFF_FFFF);
		send_cell(1'b0, 32'd65536, 32'd0, 32'd0, 32'd0, mx);
		send_cell(1'b1, 32'd65536, 32'd0, 32'd0, 32'd0, mx);
		send_cell(1'b0, 32'd1, 32'd0, 32'd0, 32'd0, mx);
		no_gaps = 1'b1;
		random_cells(200);
		no_gaps = 1'b0;

		// gamma at one and zero coefficients
		set_config(32'd65536, 32'h8000_0000, 32'd0);
		send_cell(1'b0, 32'd65536, 32'd0, 32'd0, 32'd0, mx);
		send_cell(1'b1, 32'd65536, 32'd0, 32'd0, 32'd0, mx);
		random_cells(150);

		// gamma below one
		set_config(32'd0, 32'd1, 32'd1);
		send_cell(1'b0, 32'd65536, 32'd0, 32'd0, 32'd0, mx);
		random_cells(150);

		set_config(32'd131072, 32'd1, 32'd65536 * 3);
		random_cells(200);

		set_config($urandom_range(196608, 65536), $urandom_range(32'h7FFF_FFFF, 1),
			$urandom_range(32'h7FFF_FFFF, 1));
		random_cells(250);

		drain();
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
